[hw/rtl/pndip_pkg.sv]
// Shared types, constants and the CORDIC step function for the plane attitude unit.
// No dependencies; imported by plane_normal_to_dip_angles_unit.
`timescale 1ns / 1ps

package pndip_pkg;

  // Default number of CORDIC rotations per angle, and the table length that bounds it.
  localparam int unsigned ANGLE_ITERATIONS_DEF = 16;
  localparam int unsigned TABLE_LEN            = 24;

  // Square root of a 32-bit value shifted up by 32 bits: one result bit per step.
  localparam int unsigned SQRT_STEPS = 32;

  // Angles are held in units of 2^-16 hundredths of a degree.
  localparam logic [31:0] QUARTER_FX = 32'd589824000;   // 9000 << 16
  localparam logic [31:0] HALF_FX    = 32'd1179648000;  // 18000 << 16
  localparam logic [31:0] FULL_FX    = 32'd2359296000;  // 36000 << 16
  localparam logic [31:0] ROUND_HALF = 32'd32768;
  localparam logic [16:0] FULL_TURN  = 17'd36000;

  // atan(2^-i) in the angle units above, rounded.
  localparam logic signed [31:0] ATAN_TABLE [TABLE_LEN] = '{
    32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
    32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
    32'sd1466764,   32'sd733385,    32'sd366693,   32'sd183346,
    32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
    32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
    32'sd358,       32'sd179,       32'sd90,       32'sd45
  };

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_HORIZONTAL = 2'd1,
    ST_ZERO       = 2'd2
  } status_t;

  // Facts about one word that ride along beside the arithmetic.
  typedef struct packed {
    logic [16:0] ax;      // |x| after the flip to z >= 0
    logic [16:0] ay;      // |y|
    logic [16:0] az;      // |z|
    logic        xneg;    // flipped x is negative
    logic        ypos;    // flipped y is positive
    status_t     status;
  } side_t;

  typedef struct packed {
    logic signed [35:0] a;
    logic signed [35:0] b;
    logic signed [31:0] ang;
  } cordic_t;

  // One vectoring rotation; idx is a constant at every call site.
  function automatic cordic_t pndip_cordic_step(input cordic_t s, input logic [4:0] idx);
    cordic_t            r;
    logic signed [35:0] da;
    logic signed [35:0] db;
    da = s.b >>> idx;
    db = s.a >>> idx;
    if (!s.b[35]) begin
      r.a   = s.a + da;
      r.b   = s.b - db;
      r.ang = s.ang + ATAN_TABLE[idx];
    end else begin
      r.a   = s.a - da;
      r.b   = s.b + db;
      r.ang = s.ang - ATAN_TABLE[idx];
    end
    return r;
  endfunction

endpackage

[hw/rtl/plane_normal_to_dip_angles_unit.sv]
// Plane attitude unit: plane normal in, dip angle and dip direction out.
// Depends on pndip_pkg (types, angle table, CORDIC step).
`timescale 1ns / 1ps
//
//  Channel   Ports                                      Direction  Content
//  in        in_valid/in_ready, in_normal_x/y/z         input      normal, signed Q1.14
//  out       out_valid/out_ready, out_dip_angle,        output     attitude in 1/100 degree,
//            out_dip_direction, out_status                         status code
//
//  The unit accepts one word every cycle while out_ready is high or the output register
//  is empty. Its stages, in order: the sign flip, the squares, their sum, the
//  bit-per-step square root, the CORDIC rotations, and clamp and rounding.
//  Reset is synchronous and active low; it clears only the valid bits of the stages.
//  When a result waits at the output and out_ready is low, every stage holds, so
//  in_ready drops in the same cycle; nothing is lost or repeated.

module plane_normal_to_dip_angles_unit #(
  parameter int unsigned ANGLE_ITERATIONS = pndip_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [13:0] out_dip_angle,
  output logic        [15:0] out_dip_direction,
  output logic        [1:0]  out_status
);

  import pndip_pkg::*;

  localparam int unsigned NIT = ANGLE_ITERATIONS;

  // Whole pipeline moves together whenever the output register can take a word.
  logic en;
  logic out_valid_r;
  assign en       = out_ready || !out_valid_r;
  assign in_ready = en;

  // Stage 0: flip the normal to the upper half space and take magnitudes.
  logic               v0_r;
  side_t              side0_r;
  side_t              side0_nxt;
  logic signed [16:0] xn;
  logic signed [16:0] yn;
  logic signed [16:0] zn;

  always_comb begin
    if (in_normal_z[15]) begin
      xn = -{in_normal_x[15], in_normal_x};
      yn = -{in_normal_y[15], in_normal_y};
      zn = -{in_normal_z[15], in_normal_z};
    end else begin
      xn = {in_normal_x[15], in_normal_x};
      yn = {in_normal_y[15], in_normal_y};
      zn = {in_normal_z[15], in_normal_z};
    end
    side0_nxt.ax   = xn[16] ? 17'(-xn) : 17'(xn);
    side0_nxt.ay   = yn[16] ? 17'(-yn) : 17'(yn);
    side0_nxt.az   = 17'(zn);
    side0_nxt.xneg = xn[16];
    side0_nxt.ypos = !yn[16] && (yn != 17'sd0);
    if (xn == 17'sd0 && yn == 17'sd0) begin
      side0_nxt.status = (zn == 17'sd0) ? ST_ZERO : ST_HORIZONTAL;
    end else begin
      side0_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side0_r <= side0_nxt;
    end
  end

  // Stage 1: the two squares.
  logic        v1_r;
  side_t       side1_r;
  logic [30:0] sqx1_r;
  logic [30:0] sqy1_r;
  logic [33:0] px;
  logic [33:0] py;

  assign px = side0_r.ax * side0_r.ax;
  assign py = side0_r.ay * side0_r.ay;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side0_r;
      sqx1_r  <= px[30:0];
      sqy1_r  <= py[30:0];
    end
  end

  // Stage 2: x^2 + y^2, at most 2^31.
  logic        v2_r;
  side_t       side2_r;
  logic [31:0] sq2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2_r <= side1_r;
      sq2_r   <= {1'b0, sqx1_r} + {1'b0, sqy1_r};
    end
  end

  // Square root of sq * 2^32, one result bit per stage. The low 32 radicand bits
  // are zero, so the last sixteen steps bring in zero bit pairs.
  logic        sv_r    [SQRT_STEPS];
  side_t       sside_r [SQRT_STEPS];
  logic [31:0] srad_r  [SQRT_STEPS];
  logic [33:0] srem_r  [SQRT_STEPS];
  logic [31:0] sroot_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic        v_in;
    side_t       side_in;
    logic [31:0] rad_in;
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [1:0]  pair;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign v_in    = v2_r;
      assign side_in = side2_r;
      assign rad_in  = sq2_r;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = sv_r[k-1];
      assign side_in = sside_r[k-1];
      assign rad_in  = srad_r[k-1];
      assign rem_in  = srem_r[k-1];
      assign root_in = sroot_r[k-1];
    end

    if (k < SQRT_STEPS / 2) begin : g_bits
      assign pair = rad_in[31-2*k -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign rem_sh = {rem_in, pair};
    assign trial  = {2'b00, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k] <= 1'b0;
      end else if (en) begin
        sv_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sside_r[k] <= side_in;
        srad_r[k]  <= rad_in;
        srem_r[k]  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
        sroot_r[k] <= {root_in[30:0], ge};
      end
    end
  end

  // CORDIC vectoring, one rotation per stage, both angles side by side.
  logic    cv_r    [NIT];
  side_t   cside_r [NIT];
  cordic_t cdip_r  [NIT];
  cordic_t cdir_r  [NIT];

  for (genvar i = 0; i < NIT; i++) begin : g_cordic
    logic    v_in;
    side_t   side_in;
    cordic_t dip_in;
    cordic_t dir_in;

    if (i == 0) begin : g_first
      assign v_in       = sv_r[SQRT_STEPS-1];
      assign side_in    = sside_r[SQRT_STEPS-1];
      assign dip_in.a   = {3'b000, sside_r[SQRT_STEPS-1].az, 16'h0000};
      assign dip_in.b   = {4'h0, sroot_r[SQRT_STEPS-1]};
      assign dip_in.ang = '0;
      assign dir_in.a   = {3'b000, sside_r[SQRT_STEPS-1].ax, 16'h0000};
      assign dir_in.b   = {3'b000, sside_r[SQRT_STEPS-1].ay, 16'h0000};
      assign dir_in.ang = '0;
    end else begin : g_next
      assign v_in    = cv_r[i-1];
      assign side_in = cside_r[i-1];
      assign dip_in  = cdip_r[i-1];
      assign dir_in  = cdir_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i] <= 1'b0;
      end else if (en) begin
        cv_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cside_r[i] <= side_in;
        cdip_r[i]  <= pndip_cordic_step(dip_in, 5'(i));
        cdir_r[i]  <= pndip_cordic_step(dir_in, 5'(i));
      end
    end
  end

  // Clamp both angles to a quarter turn, round the dip and unfold the direction
  // into its quadrant.
  logic        fv_r;
  status_t     fstat_r;
  logic [13:0] fdip_r;
  logic [31:0] ft_r;
  logic [31:0] dip_c;
  logic [31:0] base_c;
  logic [31:0] dip_sum;
  logic [31:0] t_half;
  logic [31:0] t_full;
  cordic_t     dip_last;
  cordic_t     dir_last;
  side_t       side_last;

  assign dip_last  = cdip_r[NIT-1];
  assign dir_last  = cdir_r[NIT-1];
  assign side_last = cside_r[NIT-1];

  always_comb begin
    priority if (dip_last.ang[31]) begin
      dip_c = '0;
    end else if (dip_last.ang > $signed(QUARTER_FX)) begin
      dip_c = QUARTER_FX;
    end else begin
      dip_c = dip_last.ang;
    end
    priority if (dir_last.ang[31]) begin
      base_c = '0;
    end else if (dir_last.ang > $signed(QUARTER_FX)) begin
      base_c = QUARTER_FX;
    end else begin
      base_c = dir_last.ang;
    end
    dip_sum = dip_c + ROUND_HALF;
    t_half  = side_last.xneg ? (HALF_FX - base_c) : base_c;
    t_full  = side_last.ypos ? (FULL_FX - t_half) : t_half;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (en) begin
      fv_r <= cv_r[NIT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fstat_r <= side_last.status;
      fdip_r  <= dip_sum[29:16];
      ft_r    <= t_full;
    end
  end

  // Output register: round the direction, wrap a full turn to zero, and zero the
  // angles of a horizontal plane or a zero normal.
  logic [32:0] dir_sum;
  logic [16:0] dir_rnd;
  logic [13:0] out_dip_r;
  logic [15:0] out_dir_r;
  status_t     out_stat_r;

  assign dir_sum = {1'b0, ft_r} + {1'b0, ROUND_HALF};
  assign dir_rnd = dir_sum[32:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stat_r <= fstat_r;
      if (fstat_r != ST_OK) begin
        out_dip_r <= '0;
        out_dir_r <= '0;
      end else begin
        out_dip_r <= fdip_r;
        out_dir_r <= (dir_rnd >= FULL_TURN) ? 16'd0 : dir_rnd[15:0];
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_dip_angle     = out_dip_r;
  assign out_dip_direction = out_dir_r;
  assign out_status        = out_stat_r;

  // A valid result always carries an in-range attitude.
  a_dip_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dip_angle <= 14'd9000)
    else $error("dip angle above a quarter turn");

  a_dir_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dip_direction < 16'd36000)
    else $error("dip direction not wrapped");

  a_flag_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_dip_angle == 14'd0 && out_dip_direction == 16'd0)
    else $error("flagged result carries nonzero angles");

  a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_HORIZONTAL || out_status == ST_ZERO)
    else $error("undefined status code");

  a_hold_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(fv_r) && $stable(ft_r))
    else $error("pipeline moved during a stall");

endmodule

[test/tb_top.sv]
// Self-checking testbench for plane_normal_to_dip_angles_unit: directed and random normals.
// Depends on pndip_pkg (status codes, angle table, iteration count) and the unit's RTL.
`timescale 1ns / 1ps

module tb_top;
  import pndip_pkg::*;

  // One expected attitude word, in the widths of the result ports.
  typedef struct {
    logic [13:0] dip;
    logic [15:0] dir;
    status_t     st;
  } attitude_t;

  // One row of the directed table. When typed is set, the attitude is written in
  // by hand; otherwise it comes from the predictor.
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    bit                 typed;
    attitude_t          att;
  } normal_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_normal_x;
  logic signed [15:0] in_normal_y;
  logic signed [15:0] in_normal_z;
  logic               out_valid;
  logic               out_ready;
  logic        [13:0] out_dip_angle;
  logic        [15:0] out_dip_direction;
  logic        [1:0]  out_status;

  plane_normal_to_dip_angles_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_normal_x       (in_normal_x),
    .in_normal_y       (in_normal_y),
    .in_normal_z       (in_normal_z),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_dip_angle     (out_dip_angle),
    .out_dip_direction (out_dip_direction),
    .out_status        (out_status)
  );

  // Attitudes still owed by the unit, oldest first.
  attitude_t attitudes_due[$];

  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned mismatches;
  int unsigned snd_idle_pct;
  int unsigned rcv_stall_pct;
  bit          rcv_hold;

  always #5 clk = ~clk;

  // The generous upper bound on the whole run; a correct run ends far sooner.
  initial begin
    #3000000;
    $display("[plane_normal_to_dip_angles_unit] ERROR");
    $finish;
  end

  // Floor square root of a 64-bit value, one result bit per two input bits.
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // CORDIC vectoring angle of (a, b) in 2^-16 hundredths of a degree, clamped to a quarter.
  // The arithmetic shift of a signed value is a floor division by a power of two.
  function automatic longint vector_angle(input longint a, input longint b);
    longint ang;
    longint da;
    longint db;
    ang = 0;
    for (int i = 0; i < ANGLE_ITERATIONS_DEF && i < TABLE_LEN; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a   = a + da;
        b   = b - db;
        ang = ang + longint'(ATAN_TABLE[i]);
      end else begin
        a   = a - da;
        b   = b + db;
        ang = ang - longint'(ATAN_TABLE[i]);
      end
    end
    if (ang < 0) ang = 0;
    if (ang > longint'(QUARTER_FX)) ang = longint'(QUARTER_FX);
    return ang;
  endfunction

  // Full attitude of one normal, in 64-bit arithmetic so no step can overflow.
  function automatic attitude_t predict_attitude(input logic signed [15:0] nx,
                                                 input logic signed [15:0] ny,
                                                 input logic signed [15:0] nz);
    attitude_t r;
    longint    x;
    longint    y;
    longint    z;
    longint    h;
    longint    t;
    longint    dirv;
    x = nx;
    y = ny;
    z = nz;
    r.dip = '0;
    r.dir = '0;
    r.st  = ST_OK;
    // A downward normal is turned to point up.
    if (z < 0) begin
      x = -x;
      y = -y;
      z = -z;
    end
    if (x == 0 && y == 0) begin
      r.st = (z == 0) ? ST_ZERO : ST_HORIZONTAL;
    end else begin
      h     = longint'(root_floor(longint'(x * x + y * y) << 32));
      r.dip = 14'((vector_angle(z * 65536, h) + 32768) >>> 16);
      t = vector_angle((x < 0 ? -x : x) * 65536, (y < 0 ? -y : y) * 65536);
      if (x < 0) t = longint'(HALF_FX) - t;
      if (y > 0) t = longint'(FULL_FX) - t;
      dirv = (t + 32768) >>> 16;
      // A direction that rounds to a full turn is reported as zero.
      if (dirv >= 36000) dirv = 0;
      r.dir = 16'(dirv);
    end
    return r;
  endfunction

  // Offers one normal and returns once the unit has taken it. The item's attitude is
  // queued at the accepting edge, well ahead of the result it describes.
  task automatic offer_normal(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic signed [15:0] z, input bit typed,
                              input attitude_t att);
    bit taken;
    in_valid    <= 1'b1;
    in_normal_x <= x;
    in_normal_y <= y;
    in_normal_z <= z;
    taken = 1'b0;
    while (!taken) begin
      // in_ready is settled by the falling edge and holds through the next rise.
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    attitudes_due.push_back(typed ? att : predict_attitude(x, y, z));
    words_sent++;
    // The sender idles for a random number of cycles after the word, per phase.
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // A random component: mostly inside the Q1.14 unit range, sometimes anywhere in
  // 16 bits, sometimes zero or tiny so that axis and near-axis cases show up.
  function automatic logic signed [15:0] random_component();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return 16'(int'($urandom_range(32768)) - 16384);
    if (pick < 75) return 16'($urandom);
    if (pick < 85) return 16'sd0;
    if (pick < 95) return 16'(int'($urandom_range(8)) - 4);
    return ($urandom_range(1) != 0) ? 16'sh8000 : 16'sh7fff;
  endfunction

  task automatic offer_random(input int unsigned count);
    attitude_t none;
    none = '{dip: '0, dir: '0, st: ST_OK};
    repeat (count)
      offer_normal(random_component(), random_component(), random_component(), 1'b0, none);
  endtask

  // The receiver: random stalls per phase, or a long hold-off when asked.
  initial begin
    int unsigned held;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rcv_hold) begin
        out_ready <= 1'b0;
        held = 0;
        while (held < 400) begin
          @(posedge clk);
          held++;
        end
        rcv_hold = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
      @(posedge clk);
    end
  end

  // Result checker: every word taken at the output is compared with the oldest
  // expected attitude, field by field.
  always @(posedge clk) begin
    attitude_t want;
    if (rst_n && out_valid && out_ready) begin
      if (attitudes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: dip %0d dir %0d status %0d",
                   out_dip_angle, out_dip_direction, out_status);
      end else begin
        want = attitudes_due.pop_front();
        words_checked++;
        if (out_dip_angle !== want.dip || out_dip_direction !== want.dir ||
            out_status !== want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: expected dip %0d dir %0d status %0d, got %0d %0d %0d",
                     words_checked, want.dip, want.dir, want.st,
                     out_dip_angle, out_dip_direction, out_status);
        end
      end
    end
  end

  // Directed normals: empty and vertical normals have attitudes read off at a glance;
  // the rest go through the predictor.
  localparam int N_ROWS = 20;
  normal_row_t directed [N_ROWS];

  initial begin
    attitude_t none;
    none = '{dip: '0, dir: '0, st: ST_OK};
    directed = '{
      '{16'sd0,      16'sd0,      16'sd0,      1'b1, '{14'd0, 16'd0, ST_ZERO}},
      '{16'sd0,      16'sd0,      16'sd16384,  1'b1, '{14'd0, 16'd0, ST_HORIZONTAL}},
      '{16'sd0,      16'sd0,      -16'sd16384, 1'b1, '{14'd0, 16'd0, ST_HORIZONTAL}},
      '{16'sd0,      16'sd0,      16'sh8000,   1'b1, '{14'd0, 16'd0, ST_HORIZONTAL}},
      '{16'sd0,      16'sd0,      16'sh7fff,   1'b1, '{14'd0, 16'd0, ST_HORIZONTAL}},
      // Vertical planes along each axis, then extreme components, including the most negative value.
      '{16'sd16384,  16'sd0,      16'sd0,      1'b0, none},
      '{-16'sd16384, 16'sd0,      16'sd0,      1'b0, none},
      '{16'sd0,      16'sd16384,  16'sd0,      1'b0, none},
      '{16'sd0,      -16'sd16384, 16'sd0,      1'b0, none},
      '{16'sh8000,   16'sh8000,   16'sd0,      1'b0, none},
      '{16'sh7fff,   16'sh7fff,   16'sh7fff,   1'b0, none},
      '{16'sh8000,   16'sh7fff,   16'sh8000,   1'b0, none},
      // Tiny horizontal parts next to a large vertical one: dip near zero.
      '{16'sd1,      16'sd0,      16'sd16384,  1'b0, none},
      '{16'sd0,      -16'sd1,     16'sd16384,  1'b0, none},
      // Just below the +x axis with y positive: the direction wraps around a full turn.
      '{16'sd16384,  16'sd1,      16'sd100,    1'b0, none},
      '{16'sd16384,  -16'sd1,     16'sd100,    1'b0, none},
      // A downward normal is flipped before anything else.
      '{16'sd9000,   -16'sd5000,  -16'sd12000, 1'b0, none},
      '{-16'sd11585, 16'sd11585,  16'sd1,      1'b0, none},
      '{16'sd11585,  16'sd11585,  16'sd11585,  1'b0, none},
      '{-16'sd1,     -16'sd1,     -16'sd1,     1'b0, none}
    };
  end

  initial begin
    clk           = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_normal_x   <= '0;
    in_normal_y   <= '0;
    in_normal_z   <= '0;
    words_sent    = 0;
    words_checked = 0;
    mismatches    = 0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    rcv_hold      = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, back to back.
    foreach (directed[i])
      offer_normal(directed[i].x, directed[i].y, directed[i].z,
                   directed[i].typed, directed[i].att);

    // Random phases: free flow, then a slow sender, a slow receiver, and light
    // stalls on both sides.
    snd_idle_pct = 0;  rcv_stall_pct = 0;  offer_random(300);
    snd_idle_pct = 78; rcv_stall_pct = 0;  offer_random(300);
    snd_idle_pct = 0;  rcv_stall_pct = 78; offer_random(300);
    snd_idle_pct = 12; rcv_stall_pct = 12; offer_random(300);

    // The receiver holds off for a long stretch while the sender keeps offering,
    // so the pipeline fills and in_ready drops.
    snd_idle_pct = 0;  rcv_stall_pct = 0;
    rcv_hold = 1'b1;
    offer_random(150);

    // The sender pauses until the unit has drained, then resumes.
    in_valid <= 1'b0;
    while (attitudes_due.size() != 0) @(posedge clk);
    offer_random(180);

    in_valid <= 1'b0;
    while (attitudes_due.size() != 0) @(posedge clk);
    // Give a stray extra word time to appear.
    repeat (80) @(posedge clk);

    $display("Sent %0d normals (directed table and random phases with idling and a long",
             words_sent);
    $display("output hold-off); %0d attitudes checked, %0d mismatches.",
             words_checked, mismatches);
    if (mismatches == 0) begin
      $display("[plane_normal_to_dip_angles_unit] OK");
    end else begin
      $display("[plane_normal_to_dip_angles_unit] ERROR");
    end
    $finish;
  end

endmodule
